// ===== sv/fucs_pkg.sv =====
// Shared constants and types for the first-unique-character stream block.
package fucs_pkg;

    // Character codes
    localparam logic [7:0] LETTER_BASE = 8'h61;  // 'a'
    localparam logic [7:0] EMPTY_MARK  = 8'h23;  // '#'

    // Control for one step of the letter list
    typedef struct packed {
        logic en;         // an item is transferred this cycle
        logic clear;      // start of a new string: wipe letter state first
        logic letter_ok;  // byte is a letter of the alphabet
    } t_step_ctl;

endpackage

// ===== sv/fucs_char_decode.sv =====
// Byte classifier: checks for a letter and yields its index.
module fucs_char_decode #(
    parameter int ALPHABET_SIZE = 26,
    localparam int IW = $clog2(ALPHABET_SIZE)
) (
    input  logic [7:0]    i_char_byte,
    output logic          o_letter_ok,
    output logic [IW-1:0] o_letter_idx
);

    logic [7:0] offset;

    // Offset from 'a'; a letter lies in the first ALPHABET_SIZE codes from there
    assign offset       = i_char_byte - fucs_pkg::LETTER_BASE;
    assign o_letter_ok  = (i_char_byte >= fucs_pkg::LETTER_BASE)
                       && ({1'b0, offset} < 9'(ALPHABET_SIZE));
    assign o_letter_idx = offset[IW-1:0];

endmodule

// ===== sv/fucs_letter_list.sv =====
// Letter state and doubly linked list of letters seen exactly once.
module fucs_letter_list #(
    parameter int ALPHABET_SIZE = 26,
    localparam int IW = $clog2(ALPHABET_SIZE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fucs_pkg::t_step_ctl i_ctl,
    input  logic [IW-1:0]       i_letter_idx,
    output logic                o_nonempty,
    output logic [IW-1:0]       o_head
);

    logic [ALPHABET_SIZE-1:0] r_seen, n_seen;
    logic [ALPHABET_SIZE-1:0] r_rep, n_rep;
    logic [IW-1:0]            r_head, n_head;
    logic [IW-1:0]            r_tail, n_tail;
    logic                     r_nonempty, n_nonempty;
    logic [IW-1:0]            r_next [ALPHABET_SIZE];
    logic [IW-1:0]            r_prev [ALPHABET_SIZE];

    // State as seen after an optional clear
    logic [ALPHABET_SIZE-1:0] e_seen, e_rep;
    logic [IW-1:0]            e_head, e_tail;
    logic                     e_nonempty;

    logic [IW-1:0] nx, pv;
    logic          next_we, prev_we;
    logic [IW-1:0] next_wa, next_wd, prev_wa, prev_wd;

    assign nx = r_next[i_letter_idx];
    assign pv = r_prev[i_letter_idx];

    // Work out the next list state for one transfer
    always_comb begin
        e_seen     = i_ctl.clear ? '0 : r_seen;
        e_rep      = i_ctl.clear ? '0 : r_rep;
        e_head     = i_ctl.clear ? '0 : r_head;
        e_tail     = i_ctl.clear ? '0 : r_tail;
        e_nonempty = i_ctl.clear ? 1'b0 : r_nonempty;

        n_seen     = e_seen;
        n_rep      = e_rep;
        n_head     = e_head;
        n_tail     = e_tail;
        n_nonempty = e_nonempty;
        next_we    = 1'b0;
        next_wa    = e_tail;
        next_wd    = i_letter_idx;
        prev_we    = 1'b0;
        prev_wa    = i_letter_idx;
        prev_wd    = e_tail;

        if (i_ctl.letter_ok && !e_rep[i_letter_idx]) begin
            if (!e_seen[i_letter_idx]) begin
                // First sighting: append at the tail
                n_seen[i_letter_idx] = 1'b1;
                n_tail               = i_letter_idx;
                if (!e_nonempty) begin
                    n_head     = i_letter_idx;
                    n_nonempty = 1'b1;
                end else begin
                    next_we = 1'b1;
                    prev_we = 1'b1;
                end
            end else begin
                // Second sighting: unlink and mark repeated
                n_seen[i_letter_idx] = 1'b0;
                n_rep[i_letter_idx]  = 1'b1;
                if (e_nonempty) begin
                    if (e_head == i_letter_idx && e_tail == i_letter_idx) begin
                        n_nonempty = 1'b0;
                    end else if (e_head == i_letter_idx) begin
                        n_head = nx;
                    end else if (e_tail == i_letter_idx) begin
                        n_tail = pv;
                    end else begin
                        prev_we = 1'b1;
                        prev_wa = nx;
                        prev_wd = pv;
                        next_we = 1'b1;
                        next_wa = pv;
                        next_wd = nx;
                    end
                end
            end
        end
    end

    // Hold letter flags and list ends; advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_rep      <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_nonempty <= 1'b0;
        end else if (i_ctl.en) begin
            r_seen     <= n_seen;
            r_rep      <= n_rep;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_nonempty <= n_nonempty;
        end
    end

    // Link arrays: at most one write each per transfer, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.en && next_we) begin
            r_next[next_wa] <= next_wd;
        end
        if (i_ctl.en && prev_we) begin
            r_prev[prev_wa] <= prev_wd;
        end
    end

    assign o_nonempty = n_nonempty;
    assign o_head     = n_head;

endmodule

// ===== sv/first_unique_char_stream.sv =====
// Top level: first non-repeating letter of a character stream.
//
//  Channel  Handshake           Payload
//  -------  ------------------  --------------------------------------
//  input    i_valid / o_ready   i_char_byte, i_start_of_string
//  output   o_valid / i_ready   o_first_unique, o_bad_char
//
// One item per cycle unless the output stalls: the list update and head
// lookup are done in the cycle of the transfer, and the result lands in
// the output register, valid in the cycle after the input transfer.
// A new item is taken whenever the output register is empty or is being
// emptied in the same cycle; a stalled output holds back the input.
// Synchronous active-low reset empties the list and the output register.
module first_unique_char_stream #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_byte,
    input  logic       i_start_of_string,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_first_unique,
    output logic       o_bad_char
);

    localparam int IW = $clog2(ALPHABET_SIZE);

    logic                letter_ok;
    logic [IW-1:0]       letter_idx;
    fucs_pkg::t_step_ctl step_ctl;
    logic                list_nonempty;
    logic [IW-1:0]       list_head;
    logic                xfer_in;

    logic                r_valid;
    logic [7:0]          r_first_unique;
    logic                r_bad_char;

    assign o_ready = !r_valid || i_ready;
    assign xfer_in = i_valid && o_ready;

    fucs_char_decode #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_decode (
        .i_char_byte (i_char_byte),
        .o_letter_ok (letter_ok),
        .o_letter_idx(letter_idx)
    );

    assign step_ctl.en        = xfer_in;
    assign step_ctl.clear     = i_start_of_string;
    assign step_ctl.letter_ok = letter_ok;

    fucs_letter_list #(
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (step_ctl),
        .i_letter_idx(letter_idx),
        .o_nonempty  (list_nonempty),
        .o_head      (list_head)
    );

    // Output valid: set on input transfer, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (xfer_in) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (xfer_in) begin
            r_first_unique <= list_nonempty ? fucs_pkg::LETTER_BASE + 8'(list_head)
                                            : fucs_pkg::EMPTY_MARK;
            r_bad_char     <= !letter_ok;
        end
    end

    assign o_valid        = r_valid;
    assign o_first_unique = r_first_unique;
    assign o_bad_char     = r_bad_char;

    // A transfer always leaves a result waiting
    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer_in |=> o_valid)
        else $error("no result after input transfer");

    // A result is a letter of the alphabet or the empty mark
    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_unique == fucs_pkg::EMPTY_MARK)
                 || ((o_first_unique >= fucs_pkg::LETTER_BASE)
                  && ({1'b0, o_first_unique}
                      < {1'b0, fucs_pkg::LETTER_BASE} + 9'(ALPHABET_SIZE))))
        else $error("result outside alphabet");

    // A fresh string opening with a letter reports that letter
    a_fresh_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer_in && i_start_of_string && letter_ok)
            |=> (o_first_unique == $past(i_char_byte)) && !o_bad_char)
        else $error("fresh string does not report its first letter");

    // A fresh string opening with a bad byte reports the empty mark
    a_fresh_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (xfer_in && i_start_of_string && !letter_ok)
            |=> (o_first_unique == fucs_pkg::EMPTY_MARK) && o_bad_char)
        else $error("fresh string with bad byte not empty");

endmodule
